// ===== design/kmp_pkg.sv =====
`timescale 1ns / 1ps
// kmp_pkg: shared constants, payload types, states and command/status structs
// for the kmp pattern matcher. No dependencies.
package kmp_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int OFFSET_BITS = 32;
  localparam int LEN_W       = 5;
  localparam int PADDR_W     = $clog2(MAX_PATTERN);
  localparam int FAIL_DEPTH  = MAX_PATTERN + 1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_start;
    logic       string_end;
  } text_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        found;
    logic [31:0] position;
    logic        final_result;
  } result_item_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_SEARCH_MODE    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_ALL   = 2'd1,
    MODE_LAST  = 2'd2
  } search_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_INIT,
    ST_BUILD_FETCH,
    ST_BUILD_STEP,
    ST_WALK,
    ST_HIT,
    ST_FINISH,
    ST_SUMMARY
  } state_t;

  typedef struct packed {
    logic load_item;
    logic build_init;
    logic build_fetch;
    logic build_step;
    logic walk;
    logic hit;
    logic finish;
    logic emit_occ;
    logic emit_sum;
  } kmp_cmd_t;

  typedef struct packed {
    logic in_start;
    logic item_end;
    logic cfg_len_one;
    logic build_more;
    logic build_last;
    logic walk_more;
    logic walk_hit;
    logic mode_all;
    logic out_free;
  } kmp_status_t;

endpackage

// ===== design/kmp_pattern_matcher.sv =====
`timescale 1ns / 1ps
// kmp_pattern_matcher: streaming knuth-morris-pratt search, one text byte per request.
// sequence: a byte is loaded, walks its failure links, takes a hit step on a match, then a
// finish step, and a summary step at string end; a step that emits a result waits on
// result_ready. A string start first builds the failure table from the configured pattern.
// throughput: one byte in flight, so a new request is taken only after the previous one ends.
// reset: config returns to a one-byte zero pattern, mode first; match state cleared.
module kmp_pattern_matcher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_ready,
  input  kmp_pkg::text_item_t   text_item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output kmp_pkg::result_item_t result_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data
);
  import kmp_pkg::*;

  kmp_cmd_t    cmd;
  kmp_status_t st;

  kmp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .st         (st),
    .cmd        (cmd)
  );

  kmp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .text_item    (text_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

// ===== design/kmp_ctrl.sv =====
`timescale 1ns / 1ps
// kmp_ctrl: sequencer for table build, failure walk, hit report and summary.
// Depends on kmp_pkg.
module kmp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_ready,
  input  kmp_pkg::kmp_status_t st,
  output kmp_pkg::kmp_cmd_t    cmd
);
  import kmp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (text_valid) begin
          state_next = st.in_start ? ST_BUILD_INIT : ST_WALK;
        end
      end
      ST_BUILD_INIT: begin
        state_next = st.cfg_len_one ? ST_WALK : ST_BUILD_FETCH;
      end
      ST_BUILD_FETCH: begin
        state_next = ST_BUILD_STEP;
      end
      ST_BUILD_STEP: begin
        if (!st.build_more) begin
          state_next = st.build_last ? ST_WALK : ST_BUILD_FETCH;
        end
      end
      ST_WALK: begin
        if (!st.walk_more) begin
          state_next = st.walk_hit ? ST_HIT : ST_FINISH;
        end
      end
      ST_HIT: begin
        if (!st.mode_all || st.out_free) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = st.item_end ? ST_SUMMARY : ST_IDLE;
      end
      ST_SUMMARY: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    text_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        text_ready    = 1'b1;
        cmd.load_item = text_valid;
      end
      ST_BUILD_INIT:  cmd.build_init  = 1'b1;
      ST_BUILD_FETCH: cmd.build_fetch = 1'b1;
      ST_BUILD_STEP:  cmd.build_step  = 1'b1;
      ST_WALK:        cmd.walk        = 1'b1;
      ST_HIT: begin
        cmd.hit      = !st.mode_all || st.out_free;
        cmd.emit_occ = st.mode_all && st.out_free;
      end
      ST_FINISH:  cmd.finish   = 1'b1;
      ST_SUMMARY: cmd.emit_sum = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/kmp_datapath.sv =====
`timescale 1ns / 1ps
// kmp_datapath: config registers, latched pattern, failure table, match state
// and result register. Depends on kmp_pkg.
module kmp_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  kmp_pkg::text_item_t   text_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output kmp_pkg::result_item_t result_item,
  input  kmp_pkg::kmp_cmd_t     cmd,
  output kmp_pkg::kmp_status_t  st
);
  import kmp_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  // config registers
  logic [63:0]      cfg_pat_low;
  logic [63:0]      cfg_pat_high;
  logic [LEN_W-1:0] cfg_len;
  logic [1:0]       cfg_mode;

  // latched per string
  logic [MAX_PATTERN*8-1:0] pat;
  logic [LEN_W-1:0]         pat_len;
  logic [1:0]               mode;
  logic [LEN_W-1:0]         fail [FAIL_DEPTH];

  text_item_t       item;
  logic [LEN_W-1:0] bi;
  logic [LEN_W-1:0] bk;
  logic [LEN_W-1:0] j;
  logic [7:0]       cmp_byte;

  logic [LEN_W-1:0]       matched;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] first_ofs;
  logic [OFFSET_BITS-1:0] latest_ofs;
  logic                   any_match;

  logic [LEN_W-1:0]       cfg_len_eff;
  logic [PADDR_W-1:0]     pat_addr;
  logic [7:0]             pat_rd;
  logic [LEN_W-1:0]       fail_addr;
  logic [LEN_W-1:0]       fail_rd;
  logic                   build_eq;
  logic                   walk_eq;
  logic [LEN_W-1:0]       build_k_next;
  logic [LEN_W-1:0]       walk_j_next;
  logic [LEN_W-1:0]       bi_inc;
  logic [OFFSET_BITS-1:0] hit_pos;
  logic [OFFSET_BITS-1:0] sum_pos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_pat_low  <= '0;
      cfg_pat_high <= '0;
      cfg_len      <= LEN_W'(1);
      cfg_mode     <= MODE_FIRST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:    cfg_pat_low  <= cfg_data;
        REG_PATTERN_HIGH:   cfg_pat_high <= cfg_data;
        REG_PATTERN_LENGTH: cfg_len      <= cfg_data[LEN_W-1:0];
        REG_SEARCH_MODE:    cfg_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_len == '0) begin
      cfg_len_eff = LEN_W'(1);
    end else if (cfg_len > LEN_W'(MAX_PATTERN)) begin
      cfg_len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      cfg_len_eff = cfg_len;
    end
  end

  // single read port on pattern and failure table
  always_comb begin
    if (cmd.build_fetch) begin
      pat_addr = bi[PADDR_W-1:0];
    end else if (cmd.build_step) begin
      pat_addr = bk[PADDR_W-1:0];
    end else begin
      pat_addr = j[PADDR_W-1:0];
    end
  end

  assign pat_rd    = pat[pat_addr*8 +: 8];
  assign fail_addr = cmd.build_step ? bk : j;
  assign fail_rd   = fail[fail_addr];

  assign build_eq     = (cmp_byte == pat_rd);
  assign walk_eq      = (item.text_byte == pat_rd);
  assign build_k_next = bk + LEN_W'(build_eq);
  assign walk_j_next  = j + LEN_W'(walk_eq);
  assign bi_inc       = bi + LEN_W'(1);

  assign hit_pos = (byte_offset >= OFFSET_MAX) ? OFFSET_MAX :
                   byte_offset - OFFSET_BITS'(pat_len - LEN_W'(1));
  assign sum_pos = !any_match ? '0 :
                   (mode == MODE_LAST) ? latest_ofs : first_ofs;

  assign st.in_start    = text_item.string_start;
  assign st.item_end    = item.string_end;
  assign st.cfg_len_one = (cfg_len_eff == LEN_W'(1));
  assign st.build_more  = (bk != '0) && !build_eq;
  assign st.build_last  = (bi_inc == pat_len);
  assign st.walk_more   = (j != '0) && !walk_eq;
  assign st.walk_hit    = (walk_j_next == pat_len);
  assign st.mode_all    = (mode == MODE_ALL);
  assign st.out_free    = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= text_item;
    end
    if (cmd.build_fetch) begin
      cmp_byte <= pat_rd;
    end
    if (cmd.build_init) begin
      bi <= LEN_W'(1);
      bk <= '0;
    end else if (cmd.build_step) begin
      if (st.build_more) begin
        bk <= fail_rd;
      end else begin
        bk <= build_k_next;
        bi <= bi_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat     <= '0;
      pat_len <= LEN_W'(1);
      mode    <= MODE_FIRST;
      for (int n = 0; n < FAIL_DEPTH; n++) begin
        fail[n] <= '0;
      end
    end else if (cmd.build_init) begin
      pat     <= {cfg_pat_high, cfg_pat_low};
      pat_len <= cfg_len_eff;
      mode    <= cfg_mode;
      for (int n = 0; n < FAIL_DEPTH; n++) begin
        fail[n] <= '0;
      end
    end else if (cmd.build_step && !st.build_more) begin
      fail[bi_inc] <= build_k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j           <= '0;
      matched     <= '0;
      byte_offset <= '0;
      first_ofs   <= '0;
      latest_ofs  <= '0;
      any_match   <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        j <= (matched >= pat_len) ? '0 : matched;
      end else if (cmd.build_init) begin
        j <= '0;
      end else if (cmd.walk) begin
        j <= st.walk_more ? fail_rd : walk_j_next;
      end else if (cmd.hit) begin
        j <= fail_rd;
      end

      if (cmd.build_init || cmd.emit_sum) begin
        matched     <= '0;
        byte_offset <= '0;
        first_ofs   <= '0;
        latest_ofs  <= '0;
        any_match   <= 1'b0;
      end else begin
        if (cmd.hit) begin
          if (!any_match) begin
            first_ofs <= hit_pos;
          end
          latest_ofs <= hit_pos;
          any_match  <= 1'b1;
        end
        if (cmd.finish) begin
          matched <= j;
          if (byte_offset != OFFSET_MAX) begin
            byte_offset <= byte_offset + OFFSET_BITS'(1);
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_occ || cmd.emit_sum) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_occ) begin
      result_item.result_kind  <= 1'b0;
      result_item.found        <= 1'b1;
      result_item.position     <= 32'(hit_pos);
      result_item.final_result <= !item.string_end;
    end else if (cmd.emit_sum) begin
      result_item.result_kind  <= 1'b1;
      result_item.found        <= any_match;
      result_item.position     <= 32'(sum_pos);
      result_item.final_result <= 1'b1;
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_occ || cmd.emit_sum) |-> (!result_valid || result_ready))
    else $error("result written while slot occupied");

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_occ && cmd.emit_sum))
    else $error("two results in one cycle");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> (j < pat_len))
    else $error("match index past pattern length");

  a_matched_bound: assert property (@(posedge clk) disable iff (rst)
    matched < pat_len)
    else $error("stored match count not below pattern length");

  a_build_order: assert property (@(posedge clk) disable iff (rst)
    cmd.build_step |-> (bk < bi))
    else $error("failure build prefix not below index");

endmodule
